/* hdl/bei_pkg.sv */
// ----------------------------------------------------------------------------
// bei_pkg
// Types, widths and codes shared by the breakpoint envelope interpolator.
// ----------------------------------------------------------------------------
package bei_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int CMD_W   = 3;
  localparam int INDEX_W = 6;
  localparam int COORD_W = 16;
  localparam int TOTAL_W = 7;
  localparam int STAT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_EVAL   = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_BAD_IDX = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_RD,
    S_ADD_CMP,
    S_RM_RD,
    S_RM_WR,
    S_RD_WAIT,
    S_EV_SCAN,
    S_EV_DRAIN,
    S_EV_DECIDE,
    S_EV_MUL1,
    S_EV_MUL2,
    S_EV_SUM,
    S_EV_DIV,
    S_FINISH
  } state_t;

endpackage

/* hdl/bei_cmd_if.sv */
// ----------------------------------------------------------------------------
// bei_cmd_if
// Command channel: valid/ready transfer of one command with its operands.
// ----------------------------------------------------------------------------
interface bei_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [bei_pkg::CMD_W-1:0]    command;
  logic [bei_pkg::INDEX_W-1:0]  point_index;
  logic [bei_pkg::COORD_W-1:0]  coord_x;
  logic [bei_pkg::COORD_W-1:0]  coord_y;

  modport source (output valid, output command, output point_index,
                  output coord_x, output coord_y, input ready);
  modport sink   (input valid, input command, input point_index,
                  input coord_x, input coord_y, output ready);
endinterface

/* hdl/bei_res_if.sv */
// ----------------------------------------------------------------------------
// bei_res_if
// Result channel: valid/ready transfer of one result per command.
// ----------------------------------------------------------------------------
interface bei_res_if;
  logic                         valid;
  logic                         ready;
  logic [bei_pkg::COORD_W-1:0]  env_value;
  logic [bei_pkg::COORD_W-1:0]  read_x;
  logic [bei_pkg::COORD_W-1:0]  read_y;
  logic [bei_pkg::TOTAL_W-1:0]  point_total;
  logic [bei_pkg::STAT_W-1:0]   status;

  modport source (output valid, output env_value, output read_x, output read_y,
                  output point_total, output status, input ready);
  modport sink   (input valid, input env_value, input read_x, input read_y,
                  input point_total, input status, output ready);
endinterface

/* hdl/breakpoint_envelope_interpolator.sv */
// ----------------------------------------------------------------------------
// breakpoint_envelope_interpolator
// Sorted breakpoint table with add, remove, update, read and evaluate.
// Add shifts larger entries up, remove shifts later entries down, evaluate
// scans every entry through the single table read port and, unless it hits
// or lies outside the span, interpolates with the shared 16x16 multiplier
// and the 16-step restoring divider. An empty-table evaluate or an error goes
// straight to the result. One command in flight; the next is accepted once
// its result is registered. Reset empties the table (count to zero); entry
// contents stay undefined and no clearing pass runs.
// ----------------------------------------------------------------------------
module breakpoint_envelope_interpolator #(
  parameter int MAX_POINTS = bei_pkg::MAX_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bei_cmd_if.sink   in_cmd,
  bei_res_if.source out_res
);
  import bei_pkg::*;

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int EW   = 2 * COORD_W;

  state_t state_r, state_nxt;

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic [COORD_W-1:0] cx_r, cx_nxt;
  logic [COORD_W-1:0] cy_r, cy_nxt;

  logic [CW-1:0]      pos_r, pos_nxt;
  logic [IW-1:0]      scan_r, scan_nxt;
  logic               pend_r, pend_nxt;
  logic [IW-1:0]      pidx_r, pidx_nxt;

  logic [COORD_W-1:0] x0_r, x0_nxt, y0_r, y0_nxt;
  logic [COORD_W-1:0] xl_r, xl_nxt, yl_r, yl_nxt;
  logic [COORD_W-1:0] x1_r, x1_nxt, y1_r, y1_nxt;
  logic [COORD_W-1:0] x2_r, x2_nxt, y2_r, y2_nxt;
  logic               eq_r, eq_nxt, gt_r, gt_nxt;
  logic [COORD_W-1:0] eqy_r, eqy_nxt;

  logic [EW-1:0]      prod_r, prod_nxt, acc_r, acc_nxt;
  logic [COORD_W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [3:0]         dcnt_r, dcnt_nxt;

  logic [COORD_W-1:0] val_r, val_nxt, rx_r, rx_nxt, ry_r, ry_nxt;
  logic [STAT_W-1:0]  st_r, st_nxt;

  logic               ov_r, ov_nxt;
  logic [COORD_W-1:0] o_env_r, o_env_nxt, o_rx_r, o_rx_nxt, o_ry_r, o_ry_nxt;
  logic [TOTAL_W-1:0] o_tot_r, o_tot_nxt;
  logic [STAT_W-1:0]  o_st_r, o_st_nxt;

  logic               we;
  logic [IW-1:0]      waddr, raddr;
  logic [EW-1:0]      wdata, rdata;
  logic [COORD_W-1:0] rd_x, rd_y;

  logic [COORD_W-1:0] mul_a, mul_b;
  logic [EW-1:0]      prod;
  logic [EW-1:0]      num;
  logic [COORD_W:0]   trial;

  logic [CMPW-1:0]    idx_ext, cnt_ext;
  logic               bad_idx;
  logic [CW-1:0]      cnt_last, pos_m1, i_p1;

  bei_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_x     = rdata[EW-1:COORD_W];
  assign rd_y     = rdata[COORD_W-1:0];
  assign idx_ext  = CMPW'(idx_r);
  assign cnt_ext  = CMPW'(cnt_r);
  assign bad_idx  = idx_ext >= cnt_ext;
  assign cnt_last = cnt_r - CW'(1);
  assign pos_m1   = pos_r - CW'(1);
  assign i_p1     = pos_r + CW'(1);
  assign prod     = EW'(mul_a) * EW'(mul_b);
  assign num      = acc_r + prod_r;
  assign trial    = {rem_r, quo_r[COORD_W-1]};

  assign in_cmd.ready        = (state_r == S_IDLE);
  assign out_res.valid       = ov_r;
  assign out_res.env_value   = o_env_r;
  assign out_res.read_x      = o_rx_r;
  assign out_res.read_y      = o_ry_r;
  assign out_res.point_total = o_tot_r;
  assign out_res.status      = o_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;   idx_r  <= idx_nxt;   cx_r   <= cx_nxt;  cy_r <= cy_nxt;
    pos_r   <= pos_nxt;   scan_r <= scan_nxt;  pidx_r <= pidx_nxt;
    x0_r    <= x0_nxt;    y0_r   <= y0_nxt;    xl_r   <= xl_nxt;  yl_r <= yl_nxt;
    x1_r    <= x1_nxt;    y1_r   <= y1_nxt;    x2_r   <= x2_nxt;  y2_r <= y2_nxt;
    eq_r    <= eq_nxt;    gt_r   <= gt_nxt;    eqy_r  <= eqy_nxt;
    prod_r  <= prod_nxt;  acc_r  <= acc_nxt;
    rem_r   <= rem_nxt;   quo_r  <= quo_nxt;   dvs_r  <= dvs_nxt; dcnt_r <= dcnt_nxt;
    val_r   <= val_nxt;   rx_r   <= rx_nxt;    ry_r   <= ry_nxt;  st_r <= st_nxt;
    o_env_r <= o_env_nxt; o_rx_r <= o_rx_nxt;  o_ry_r <= o_ry_nxt;
    o_tot_r <= o_tot_nxt; o_st_r <= o_st_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;   idx_nxt  = idx_r;   cx_nxt   = cx_r;  cy_nxt = cy_r;
    pos_nxt   = pos_r;   scan_nxt = scan_r;  pidx_nxt = pidx_r;
    pend_nxt  = 1'b0;
    x0_nxt    = x0_r;    y0_nxt   = y0_r;    xl_nxt   = xl_r;  yl_nxt = yl_r;
    x1_nxt    = x1_r;    y1_nxt   = y1_r;    x2_nxt   = x2_r;  y2_nxt = y2_r;
    eq_nxt    = eq_r;    gt_nxt   = gt_r;    eqy_nxt  = eqy_r;
    prod_nxt  = prod_r;  acc_nxt  = acc_r;
    rem_nxt   = rem_r;   quo_nxt  = quo_r;   dvs_nxt  = dvs_r; dcnt_nxt = dcnt_r;
    val_nxt   = val_r;   rx_nxt   = rx_r;    ry_nxt   = ry_r;  st_nxt = st_r;
    o_env_nxt = o_env_r; o_rx_nxt = o_rx_r;  o_ry_nxt = o_ry_r;
    o_tot_nxt = o_tot_r; o_st_nxt = o_st_r;
    ov_nxt    = ov_r && !out_res.ready;
    we        = 1'b0;
    waddr     = '0;
    wdata     = {cx_r, cy_r};
    raddr     = '0;
    mul_a     = '0;
    mul_b     = '0;

    // fold in the table entry read during the scan
    if (pend_r) begin
      if (pidx_r == '0) begin
        x0_nxt = rd_x;
        y0_nxt = rd_y;
      end
      if (CW'(pidx_r) == cnt_last) begin
        xl_nxt = rd_x;
        yl_nxt = rd_y;
      end
      if (rd_x == cx_r && !eq_r) begin
        eq_nxt  = 1'b1;
        eqy_nxt = rd_y;
      end
      if (rd_x > cx_r && !gt_r) begin
        gt_nxt = 1'b1;
        x2_nxt = rd_x;
        y2_nxt = rd_y;
      end
      if (rd_x < cx_r) begin
        x1_nxt = rd_x;
        y1_nxt = rd_y;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_cmd.valid) begin
          cmd_nxt   = in_cmd.command;
          idx_nxt   = in_cmd.point_index;
          cx_nxt    = in_cmd.coord_x;
          cy_nxt    = in_cmd.coord_y;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        val_nxt   = '0;
        rx_nxt    = '0;
        ry_nxt    = '0;
        st_nxt    = STAT_OK;
        eq_nxt    = 1'b0;
        gt_nxt    = 1'b0;
        state_nxt = S_FINISH;
        unique case (cmd_r)
          CMD_ADD: begin
            if (cnt_r == CW'(MAX_POINTS)) begin
              st_nxt = STAT_FULL;
            end else begin
              pos_nxt   = cnt_r;
              state_nxt = S_ADD_RD;
            end
          end
          CMD_REMOVE: begin
            if (bad_idx) begin
              st_nxt = STAT_BAD_IDX;
            end else begin
              pos_nxt   = CW'(idx_ext[IW-1:0]);
              state_nxt = S_RM_RD;
            end
          end
          CMD_UPDATE: begin
            if (bad_idx) begin
              st_nxt = STAT_BAD_IDX;
            end else begin
              we    = 1'b1;
              waddr = idx_ext[IW-1:0];
            end
          end
          CMD_READ: begin
            if (bad_idx) begin
              st_nxt = STAT_BAD_IDX;
            end else begin
              raddr     = idx_ext[IW-1:0];
              state_nxt = S_RD_WAIT;
            end
          end
          CMD_EVAL: begin
            if (cnt_r != '0) begin
              scan_nxt  = '0;
              state_nxt = S_EV_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_ADD_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          waddr     = '0;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_FINISH;
        end else begin
          raddr     = pos_m1[IW-1:0];
          state_nxt = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        we    = 1'b1;
        waddr = pos_r[IW-1:0];
        if (rd_x > cx_r) begin
          wdata     = rdata;
          pos_nxt   = pos_m1;
          state_nxt = S_ADD_RD;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_FINISH;
        end
      end
      S_RM_RD: begin
        if (i_p1 < cnt_r) begin
          raddr     = i_p1[IW-1:0];
          state_nxt = S_RM_WR;
        end else begin
          cnt_nxt   = cnt_last;
          state_nxt = S_FINISH;
        end
      end
      S_RM_WR: begin
        we        = 1'b1;
        waddr     = pos_r[IW-1:0];
        wdata     = rdata;
        pos_nxt   = i_p1;
        state_nxt = S_RM_RD;
      end
      S_RD_WAIT: begin
        rx_nxt    = rd_x;
        ry_nxt    = rd_y;
        state_nxt = S_FINISH;
      end
      S_EV_SCAN: begin
        raddr    = scan_r;
        pend_nxt = 1'b1;
        pidx_nxt = scan_r;
        if (CW'(scan_r) == cnt_last) begin
          state_nxt = S_EV_DRAIN;
        end else begin
          scan_nxt = scan_r + IW'(1);
        end
      end
      S_EV_DRAIN: begin
        state_nxt = S_EV_DECIDE;
      end
      S_EV_DECIDE: begin
        state_nxt = S_FINISH;
        priority if (cx_r < x0_r || cx_r > xl_r) begin
          val_nxt = '0;
        end else if (cx_r == x0_r) begin
          val_nxt = y0_r;
        end else if (cx_r == xl_r) begin
          val_nxt = yl_r;
        end else if (eq_r) begin
          val_nxt = eqy_r;
        end else begin
          state_nxt = S_EV_MUL1;
        end
      end
      S_EV_MUL1: begin
        mul_a     = y1_r;
        mul_b     = x2_r - cx_r;
        prod_nxt  = prod;
        state_nxt = S_EV_MUL2;
      end
      S_EV_MUL2: begin
        mul_a     = y2_r;
        mul_b     = cx_r - x1_r;
        acc_nxt   = prod_r;
        prod_nxt  = prod;
        state_nxt = S_EV_SUM;
      end
      S_EV_SUM: begin
        rem_nxt   = num[EW-1:COORD_W];
        quo_nxt   = num[COORD_W-1:0];
        dvs_nxt   = x2_r - x1_r;
        dcnt_nxt  = '0;
        state_nxt = S_EV_DIV;
      end
      S_EV_DIV: begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = COORD_W'(trial - {1'b0, dvs_r});
          quo_nxt = {quo_r[COORD_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[COORD_W-1:0];
          quo_nxt = {quo_r[COORD_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd15) begin
          val_nxt   = quo_nxt;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!ov_r || out_res.ready) begin
          ov_nxt    = 1'b1;
          o_env_nxt = val_r;
          o_rx_nxt  = rx_r;
          o_ry_nxt  = ry_r;
          o_tot_nxt = TOTAL_W'(cnt_r);
          o_st_nxt  = st_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/bei_ram.sv */
// ----------------------------------------------------------------------------
// bei_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bei_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
